// ----- sv/apid_pkg.sv -----
// ----------------------------------------------------------------------------
// apid_pkg
// Shared widths, constants and types for the angle PID step block.
// ----------------------------------------------------------------------------
`default_nettype none

package apid_pkg;

  localparam int AngleW   = 14;
  localparam int DiffW    = 16;
  localparam int ErrW     = 13;
  localparam int DerW     = 14;
  localparam int SumW     = 16;
  localparam int GainW    = 16;
  localparam int DriveW   = 16;
  localparam int CfgIdxW  = 2;

  localparam int HalfTurn   = 2880;
  localparam int FullTurn   = 5760;
  localparam int SumCapHigh = 32000;
  localparam int SumCapLow  = -32768;
  localparam int DriveShift = 12;

  localparam int PkpW = GainW + ErrW;
  localparam int PkiW = GainW + SumW;
  localparam int PkdW = GainW + DerW;
  localparam int AccW = PkiW + 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP = 2'd0,
    CFG_KI = 2'd1,
    CFG_KD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [DerW-1:0] der;
    logic signed [SumW-1:0] sum;
  } err_t;

  typedef struct packed {
    logic signed [PkpW-1:0] kp;
    logic signed [PkiW-1:0] ki;
    logic signed [PkdW-1:0] kd;
  } prod_t;

endpackage

`default_nettype wire

// ----- sv/apid_err.sv -----
// ----------------------------------------------------------------------------
// apid_err
// Wrapped angle error, derivative and saturating integrator. Holds the
// previous error and the running sum; both advance on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module apid_err (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic signed [apid_pkg::AngleW-1:0]  meas,
  input  wire logic signed [apid_pkg::AngleW-1:0]  targ,
  input  wire logic                                fresh,
  output apid_pkg::err_t                           err_o
);

  localparam int DW = apid_pkg::DiffW;
  localparam int SW = apid_pkg::SumW;

  localparam logic signed [DW-1:0] Lim1 = DW'(apid_pkg::HalfTurn);
  localparam logic signed [DW-1:0] Lim2 = DW'(apid_pkg::HalfTurn + apid_pkg::FullTurn);
  localparam logic signed [DW-1:0] Lim3 = DW'(apid_pkg::HalfTurn + 2 * apid_pkg::FullTurn);
  localparam logic signed [DW-1:0] Adj1 = DW'(apid_pkg::FullTurn);
  localparam logic signed [DW-1:0] Adj2 = DW'(2 * apid_pkg::FullTurn);
  localparam logic signed [DW-1:0] Adj3 = DW'(3 * apid_pkg::FullTurn);

  localparam logic signed [SW:0] CapHi = (SW+1)'(apid_pkg::SumCapHigh);
  localparam logic signed [SW:0] CapLo = (SW+1)'(apid_pkg::SumCapLow);

  logic signed [apid_pkg::ErrW-1:0] last_err_r, last_err_nxt;
  logic signed [SW-1:0]             err_sum_r, err_sum_nxt;

  logic signed [DW-1:0]             diff;
  logic signed [DW-1:0]             adj;
  logic signed [DW-1:0]             wrapped;
  logic signed [apid_pkg::ErrW-1:0] err;
  logic signed [apid_pkg::ErrW-1:0] prev_err;
  logic signed [SW-1:0]             prev_sum;
  logic signed [apid_pkg::DerW-1:0] der;
  logic signed [SW:0]               sum_wide;
  logic signed [SW-1:0]             sum;

  always_comb begin
    diff = DW'(targ) - DW'(meas);
    if (diff > Lim3) begin
      adj = Adj3;
    end else if (diff > Lim2) begin
      adj = Adj2;
    end else if (diff > Lim1) begin
      adj = Adj1;
    end else if (diff < -Lim3) begin
      adj = -Adj3;
    end else if (diff < -Lim2) begin
      adj = -Adj2;
    end else if (diff < -Lim1) begin
      adj = -Adj1;
    end else begin
      adj = '0;
    end
    wrapped = diff - adj;
    err     = $signed(wrapped[apid_pkg::ErrW-1:0]);

    prev_err = fresh ? '0 : last_err_r;
    prev_sum = fresh ? '0 : err_sum_r;

    der      = apid_pkg::DerW'(err) - apid_pkg::DerW'(prev_err);
    sum_wide = (SW+1)'(prev_sum) + (SW+1)'(err);
    if (sum_wide > CapHi) begin
      sum = CapHi[SW-1:0];
    end else if (sum_wide < CapLo) begin
      sum = CapLo[SW-1:0];
    end else begin
      sum = sum_wide[SW-1:0];
    end
  end

  always_comb begin
    last_err_nxt = step ? err : last_err_r;
    err_sum_nxt  = step ? sum : err_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      err_sum_r  <= '0;
    end else begin
      last_err_r <= last_err_nxt;
      err_sum_r  <= err_sum_nxt;
    end
  end

  assign err_o.err = err;
  assign err_o.der = der;
  assign err_o.sum = sum;

endmodule

`default_nettype wire

// ----- sv/apid_mul.sv -----
// ----------------------------------------------------------------------------
// apid_mul
// The three gain products, each registered.
// ----------------------------------------------------------------------------
`default_nettype none

module apid_mul (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire apid_pkg::gains_t gains,
  input  wire apid_pkg::err_t   err_i,
  output apid_pkg::prod_t       prod_o
);

  apid_pkg::prod_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.kp <= apid_pkg::PkpW'(gains.kp) * apid_pkg::PkpW'(err_i.err);
      prod_r.ki <= apid_pkg::PkiW'(gains.ki) * apid_pkg::PkiW'(err_i.sum);
      prod_r.kd <= apid_pkg::PkdW'(gains.kd) * apid_pkg::PkdW'(err_i.der);
    end
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

// ----- sv/angle_pid_step.sv -----
// ----------------------------------------------------------------------------
// angle_pid_step
// Angle PID controller, one control tick per input word. The error is the
// target minus the measured angle wrapped into +-180 degrees; the integral
// saturates at +2000 and -2048 degrees. The drive is the gain-weighted sum
// of error, integral and derivative, shifted right 12 bits (floor) and
// clamped to 16-bit signed. While the output is not stalled, a word is
// accepted every cycle and passes four register stages: input, error/integral,
// products, and the saturated output register. Gains must be written through
// the cfg port while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_pid_step (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [apid_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [apid_pkg::GainW-1:0]           cfg_wdata,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [apid_pkg::AngleW-1:0]   in_measured_angle,
  input  wire logic signed [apid_pkg::AngleW-1:0]   in_target_angle,
  input  wire logic                                 in_new_command,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [apid_pkg::DriveW-1:0]   out_motor_drive
);

  localparam int AW = apid_pkg::AccW;
  localparam logic signed [AW-1:0] DriveMax = AW'(2 ** (apid_pkg::DriveW - 1) - 1);
  localparam logic signed [AW-1:0] DriveMin = -AW'(2 ** (apid_pkg::DriveW - 1));

  apid_pkg::gains_t gains_r, gains_nxt;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  logic signed [apid_pkg::AngleW-1:0] meas_r;
  logic signed [apid_pkg::AngleW-1:0] targ_r;
  logic                               fresh_r;

  apid_pkg::err_t  err_c;
  apid_pkg::err_t  err_r;
  apid_pkg::prod_t prod;

  logic signed [AW-1:0]               acc;
  logic signed [AW-1:0]               acc_sh;
  logic signed [apid_pkg::DriveW-1:0] drive;
  logic signed [apid_pkg::DriveW-1:0] drive_r;

  // gain registers
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      unique case (apid_pkg::cfg_idx_t'(cfg_index))
        apid_pkg::CFG_KP: gains_nxt.kp = $signed(cfg_wdata);
        apid_pkg::CFG_KI: gains_nxt.ki = $signed(cfg_wdata);
        apid_pkg::CFG_KD: gains_nxt.kd = $signed(cfg_wdata);
        default:          gains_nxt = gains_r;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy4 = !v4_r || out_ready;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    ld1  = in_valid && rdy1;
    ld2  = v1_r && rdy2;
    ld3  = v2_r && rdy3;
    ld4  = v3_r && rdy4;
    v1_nxt = ld1 ? 1'b1 : (rdy1 ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (rdy2 ? 1'b0 : v2_r);
    v3_nxt = ld3 ? 1'b1 : (rdy3 ? 1'b0 : v3_r);
    v4_nxt = ld4 ? 1'b1 : (rdy4 ? 1'b0 : v4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      gains_r <= gains_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v3_r    <= v3_nxt;
      v4_r    <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      meas_r  <= in_measured_angle;
      targ_r  <= in_target_angle;
      fresh_r <= in_new_command;
    end
    if (ld2) begin
      err_r <= err_c;
    end
    if (ld4) begin
      drive_r <= drive;
    end
  end

  apid_err u_err (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (ld2),
    .meas  (meas_r),
    .targ  (targ_r),
    .fresh (fresh_r),
    .err_o (err_c)
  );

  apid_mul u_mul (
    .clk    (clk),
    .en     (ld3),
    .gains  (gains_r),
    .err_i  (err_r),
    .prod_o (prod)
  );

  // sum, floor shift, clamp
  always_comb begin
    acc    = AW'(prod.kp) + AW'(prod.ki) + AW'(prod.kd);
    acc_sh = acc >>> apid_pkg::DriveShift;
    if (acc_sh > DriveMax) begin
      drive = DriveMax[apid_pkg::DriveW-1:0];
    end else if (acc_sh < DriveMin) begin
      drive = DriveMin[apid_pkg::DriveW-1:0];
    end else begin
      drive = acc_sh[apid_pkg::DriveW-1:0];
    end
  end

  assign in_ready        = rdy1;
  assign out_valid       = v4_r;
  assign out_motor_drive = drive_r;

endmodule

`default_nettype wire

// ----- sv/apid_chk.sv -----
// ----------------------------------------------------------------------------
// apid_chk
// Port-level checks for angle_pid_step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apid_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [apid_pkg::DriveW-1:0]        out_motor_drive
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_drive))
    else $error("result word changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output register empty the pipe cannot back up
  a_no_backup: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a result cannot show up before a word could have crossed the pipe
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!out_valid, 1) && $past(!in_valid, 1) && $past(!in_valid, 2) &&
    $past(!in_valid, 3) && $past(!in_valid, 4) && $past(in_ready, 4) &&
    $past(!out_valid, 2) && $past(!out_valid, 3) && $past(!out_valid, 4) |->
    !out_valid)
    else $error("result appeared without an input word");

endmodule

bind angle_pid_step apid_chk u_apid_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_motor_drive (out_motor_drive)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for angle_pid_step. A short directed run covers the
// angle extremes, the error wrap and both integral caps. Then eight gain
// settings follow, the extremes among them, each with about 125 random
// control ticks. The random ticks are mostly tracking runs and windup runs
// that open with a new command, plus some noise. Both channels idle at
// random. Every drive word is checked against an in-bench PID model.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int AngleSpan  = apid_pkg::FullTurn;
  localparam int AngleMin   = -(2 ** (apid_pkg::AngleW - 1));
  localparam int AngleMax   = 2 ** (apid_pkg::AngleW - 1) - 1;
  localparam int DriveMin   = -(2 ** (apid_pkg::DriveW - 1));
  localparam int DriveMax   = 2 ** (apid_pkg::DriveW - 1) - 1;
  localparam int GainMin    = -(2 ** (apid_pkg::GainW - 1));
  localparam int GainMax    = 2 ** (apid_pkg::GainW - 1) - 1;
  localparam logic [apid_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic signed [apid_pkg::AngleW-1:0] meas;
    logic signed [apid_pkg::AngleW-1:0] targ;
    logic                               fresh;
  } tick_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [apid_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [apid_pkg::GainW-1:0]         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [apid_pkg::AngleW-1:0] in_measured_angle = '0;
  logic signed [apid_pkg::AngleW-1:0] in_target_angle = '0;
  logic                               in_new_command = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [apid_pkg::DriveW-1:0] out_motor_drive;

  tick_t                              tick_queue[$];
  logic signed [apid_pkg::DriveW-1:0] drive_expect[$];

  int  gain_p = 0;
  int  gain_i = 0;
  int  gain_d = 0;
  int  prev_err = 0;
  int  err_integral = 0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  recv_hold = 0;
  int  cycles = 0;
  int  fail_count = 0;
  int  words_sent = 0;
  int  drives_checked = 0;
  int  settings = 0;
  int  cap_steps = 0;
  int  clamp_steps = 0;

  angle_pid_step dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_angle (in_measured_angle),
    .in_target_angle   (in_target_angle),
    .in_new_command    (in_new_command),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_drive   (out_motor_drive)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int idle_len(int busy_pct);
    if (calm || pick(0, 99) < busy_pct) return 0;
    return (pick(0, 9) < 8) ? pick(1, 3) : pick(8, 30);
  endfunction

  // one control tick of the PID; updates the error history
  function automatic logic signed [apid_pkg::DriveW-1:0] pid_drive(tick_t t);
    int     err;
    int     slope;
    int     integ;
    longint acc;
    if (t.fresh) begin
      prev_err = 0;
      err_integral = 0;
    end
    err = int'(t.targ) - int'(t.meas);
    while (err > apid_pkg::HalfTurn) err -= apid_pkg::FullTurn;
    while (err < -apid_pkg::HalfTurn) err += apid_pkg::FullTurn;
    slope = err - prev_err;
    integ = err_integral + err;
    if (integ > apid_pkg::SumCapHigh) integ = apid_pkg::SumCapHigh;
    else if (integ < apid_pkg::SumCapLow) integ = apid_pkg::SumCapLow;
    if (integ == apid_pkg::SumCapHigh || integ == apid_pkg::SumCapLow) cap_steps++;
    err_integral = integ;
    acc = longint'(gain_p) * err + longint'(gain_i) * integ + longint'(gain_d) * slope;
    acc = acc >>> apid_pkg::DriveShift;
    if (acc > DriveMax) begin
      acc = DriveMax;
      clamp_steps++;
    end else if (acc < DriveMin) begin
      acc = DriveMin;
      clamp_steps++;
    end
    prev_err = err;
    return acc[apid_pkg::DriveW-1:0];
  endfunction

  task automatic write_gain(logic [apid_pkg::CfgIdxW-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[apid_pkg::GainW-1:0];
    case (idx)
      apid_pkg::CFG_KP: gain_p = value;
      apid_pkg::CFG_KI: gain_i = value;
      apid_pkg::CFG_KD: gain_d = value;
      default: ;
    endcase
  endtask

  // spare index write must leave all gains alone
  task automatic set_gains(int p, int i, int d, bit spare);
    write_gain(apid_pkg::CFG_KP, p);
    write_gain(apid_pkg::CFG_KI, i);
    write_gain(apid_pkg::CFG_KD, d);
    if (spare) write_gain(CfgSpare, pick(GainMin, GainMax));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic push_tick(int m, int t, bit f);
    tick_t x;
    x.meas = m[apid_pkg::AngleW-1:0];
    x.targ = t[apid_pkg::AngleW-1:0];
    x.fresh = f;
    tick_queue.push_back(x);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || drive_expect.size() != 0);
  endtask

  task automatic queue_phase(int n);
    int done;
    int len;
    int kind;
    int m;
    int t;
    int e;
    bit neg;
    done = 0;
    while (done < n) begin
      kind = pick(0, 9);
      if (kind < 6) begin
        // tracking run: measured angle chases the target
        len = pick(2, 30);
        t = pick(-AngleSpan, AngleSpan);
        m = pick(-AngleSpan, AngleSpan);
        for (int k = 0; k < len; k++) begin
          if (k != 0 && pick(0, 9) == 0) t = pick(-AngleSpan, AngleSpan);
          push_tick(m, t, k == 0);
          m = m + (t - m) / 4 + pick(-32, 32);
          if (m > AngleSpan) m = AngleSpan;
          if (m < -AngleSpan) m = -AngleSpan;
        end
      end else if (kind < 8) begin
        // windup run: large error of one sign drives the integral toward a cap
        len = pick(12, 30);
        neg = pick(0, 1);
        for (int k = 0; k < len; k++) begin
          e = pick(2000, apid_pkg::HalfTurn);
          if (neg) e = -e;
          m = pick(-apid_pkg::HalfTurn, apid_pkg::HalfTurn);
          push_tick(m, m + e, k == 0);
        end
      end else if (kind == 8) begin
        len = pick(1, 5);
        for (int k = 0; k < len; k++)
          push_tick(pick(AngleMin, AngleMax), pick(AngleMin, AngleMax), pick(0, 1));
      end else begin
        len = pick(1, 8);
        for (int k = 0; k < len; k++)
          push_tick(pick(-AngleSpan, AngleSpan), pick(-AngleSpan, AngleSpan), pick(0, 3) == 0);
      end
      done += len;
    end
  endtask

  always @(posedge clk) begin : send_side
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (tick_queue.size() != 0) begin
        nxt = tick_queue.pop_front();
        in_valid <= 1'b1;
        in_measured_angle <= nxt.meas;
        in_target_angle <= nxt.targ;
        in_new_command <= nxt.fresh;
        send_gap <= idle_len(55);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : recv_side
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else if (recv_hold != 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      stall = idle_len(65);
      out_ready <= (stall == 0);
      recv_hold <= (stall == 0) ? 0 : stall - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      drive_expect.push_back(pid_drive(tick_t'{in_measured_angle, in_target_angle,
                                               in_new_command}));
      words_sent++;
    end
  end

  always @(posedge clk) begin : check_out
    logic signed [apid_pkg::DriveW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_expect.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected drive word %0d, nothing pending", out_motor_drive);
      end else begin
        want = drive_expect.pop_front();
        drives_checked++;
        if (out_motor_drive !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("drive word %0d: expected %0d, got %0d",
                     drives_checked, want, out_motor_drive);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_gains(256, 8, GainMax, 1'b1);
    @(negedge clk);
    push_tick(0, 0, 1'b1);
    push_tick(AngleMin, AngleMax, 1'b0);
    push_tick(AngleMax, AngleMin, 1'b0);
    push_tick(-AngleSpan, AngleSpan, 1'b0);
    push_tick(0, apid_pkg::HalfTurn + 1, 1'b0);
    push_tick(apid_pkg::HalfTurn, 0, 1'b0);
    // integral to the high cap, then to the low bound
    for (int k = 0; k < 12; k++) begin
      case (k % 3)
        0: push_tick(apid_pkg::HalfTurn, AngleSpan, k == 0);
        1: push_tick(-AngleSpan, -apid_pkg::HalfTurn, 1'b0);
        default: push_tick(0, apid_pkg::HalfTurn, 1'b0);
      endcase
    end
    for (int k = 0; k < 12; k++) begin
      if (k % 2 == 0) push_tick(AngleSpan, apid_pkg::HalfTurn, k == 0);
      else push_tick(-apid_pkg::HalfTurn, -AngleSpan, 1'b0);
    end
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2 || ph == 5);
      case (ph)
        0: set_gains(GainMax, GainMax, GainMax, 1'b0);
        1: set_gains(GainMin, GainMin, GainMin, 1'b1);
        2: set_gains(0, 0, 0, 1'b0);
        3: set_gains(pick(-512, 512), pick(-64, 64), pick(-512, 512), 1'b1);
        default: set_gains(pick(GainMin, GainMax), pick(GainMin, GainMax),
                           pick(GainMin, GainMax), pick(0, 1));
      endcase
      @(negedge clk);
      queue_phase(125);
      wait_drained();
    end

    repeat (12) @(posedge clk);
    $display("Sent %0d control ticks over %0d gain settings, %0d drive words checked.",
             words_sent, settings, drives_checked);
    $display("Integral sat at a cap on %0d ticks; drive clamped on %0d ticks.",
             cap_steps, clamp_steps);
    if (fail_count == 0 && drive_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/apid_pkg.sv
sv/apid_err.sv
sv/apid_mul.sv
sv/angle_pid_step.sv
sv/apid_chk.sv
dv/testbench.sv
